>>> sv/tsp_pkg.sv
`default_nettype none

package tsp_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_PARKING  = 3'd1,
    MODE_HOMING   = 3'd2,
    MODE_SLEWING  = 3'd3,
    MODE_PARKED   = 3'd4,
    MODE_TRACKING = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_CLOCK = 3'd1,
    REQ_GOTO  = 3'd2,
    REQ_PARK  = 3'd3,
    REQ_STOP  = 3'd4,
    REQ_HOME  = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_CLOCK = 3'd1,
    OP_GOTO  = 3'd2,
    OP_PARK  = 3'd3,
    OP_STOP  = 3'd4,
    OP_HOME  = 3'd5,
    OP_NOP   = 3'd6
  } cmd_op_t;

  typedef enum logic [2:0] {
    CFG_ALT_LOWER = 3'd0,
    CFG_ALT_UPPER = 3'd1,
    CFG_ALT_RATE  = 3'd2,
    CFG_AZ_RATE   = 3'd3,
    CFG_ALT_PARK  = 3'd4,
    CFG_AZ_PARK   = 3'd5
  } cfg_index_t;

  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  localparam int TIME_W = 32;
  localparam int REQ_W  = 3;

endpackage

`default_nettype wire

>>> sv/tsp_front.sv
`default_nettype none

module tsp_front #(
  parameter int ANGLE_BITS = 24,
  parameter int IN_TDATA_W = 80
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [IN_TDATA_W-1:0]                s_tdata,
  input  wire  [tsp_pkg::REQ_W-1:0]            s_tuser,
  input  wire                                  q_full,
  output logic                                 q_push,
  output logic [tsp_pkg::REQ_W+tsp_pkg::TIME_W+2*ANGLE_BITS-1:0] q_data
);

  localparam int FIELD_W = tsp_pkg::TIME_W + 2 * ANGLE_BITS;

  tsp_pkg::cmd_op_t op;
  logic             seen_beat;

  always_comb begin
    unique case (s_tuser)
      tsp_pkg::REQ_TICK:  op = tsp_pkg::OP_TICK;
      tsp_pkg::REQ_CLOCK: op = tsp_pkg::OP_CLOCK;
      tsp_pkg::REQ_GOTO:  op = tsp_pkg::OP_GOTO;
      tsp_pkg::REQ_PARK:  op = tsp_pkg::OP_PARK;
      tsp_pkg::REQ_STOP:  op = tsp_pkg::OP_STOP;
      tsp_pkg::REQ_HOME:  op = tsp_pkg::OP_HOME;
      default:            op = tsp_pkg::OP_NOP;
    endcase
  end

  // ready held low during reset and until a clock edge has passed with reset low
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_beat <= 1'b0;
    end else begin
      seen_beat <= 1'b1;
    end
  end

  assign s_tready = !q_full && seen_beat;
  assign q_push   = s_tvalid && s_tready;
  assign q_data   = {s_tdata[FIELD_W-1:0], op};

endmodule

`default_nettype wire

>>> sv/tsp_queue.sv
`default_nettype none

module tsp_queue #(
  parameter int WIDTH = 83
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire  [WIDTH-1:0] push_data,
  output logic             full,
  input  wire              pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign full     = count == 2'd2;
  assign valid    = count != 2'd0;
  assign pop_data = slots[rd_ptr];

endmodule

`default_nettype wire

>>> sv/tsp_back.sv
`default_nettype none

module tsp_back #(
  parameter int ANGLE_BITS     = 24,
  parameter int TIME_FRAC_BITS = 10,
  parameter int OUT_TDATA_W    = 56
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [2:0]                           cfg_index,
  input  wire  [ANGLE_BITS-1:0]                cfg_data,
  input  wire                                  q_valid,
  input  wire  [tsp_pkg::REQ_W+tsp_pkg::TIME_W+2*ANGLE_BITS-1:0] q_data,
  output logic                                 q_pop,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [OUT_TDATA_W-1:0]               m_tdata
);

  localparam int A      = ANGLE_BITS;
  localparam int NW     = A + 3;
  localparam int PW     = A + 31;
  localparam int TW     = tsp_pkg::TIME_W;
  localparam int RW     = tsp_pkg::REQ_W;
  localparam int RES_W  = 2 * A + 8;
  localparam logic [63:0] SLEW_DEFAULT = ((64'd1 << A) + 64'd180) / 64'd360;
  localparam logic [A-1:0] HALF     = {1'b1, {(A-1){1'b0}}};
  localparam logic [A-1:0] UPPER_RST = {2'b01, {(A-2){1'b0}}};
  localparam logic [A+1:0] CAP      = {1'b1, {(A+1){1'b0}}};

  // configuration
  logic signed [A-1:0] alt_lo;
  logic signed [A-1:0] alt_hi;
  logic [A-2:0]        alt_rate;
  logic [A-2:0]        az_rate;
  logic [A-1:0]        alt_park;
  logic [A-1:0]        az_park;

  // mount state
  tsp_pkg::mode_t      mode, mode_next;
  logic signed [A-1:0] alt_pos, alt_pos_next;
  logic [A-1:0]        az_pos, az_pos_next;
  logic signed [A-1:0] alt_goal, alt_goal_next;
  logic [A-1:0]        az_goal, az_goal_next;
  logic [TW-1:0]       last_time, last_time_next;
  logic [TW-1:0]       elapsed, elapsed_next;

  tsp_pkg::cmd_op_t    op;
  logic [TW-1:0]       cmd_time;
  logic signed [A-1:0] cmd_alt;
  logic [A-1:0]        cmd_az;

  assign op       = tsp_pkg::cmd_op_t'(q_data[RW-1:0]);
  assign cmd_time = q_data[RW+TW-1:RW];
  assign cmd_alt  = $signed(q_data[RW+TW+A-1:RW+TW]);
  assign cmd_az   = q_data[RW+TW+2*A-1:RW+TW+A];

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_lo   <= '0;
      alt_hi   <= $signed(UPPER_RST);
      alt_rate <= SLEW_DEFAULT[A-2:0];
      az_rate  <= SLEW_DEFAULT[A-2:0];
      alt_park <= '0;
      az_park  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsp_pkg::CFG_ALT_LOWER: alt_lo   <= $signed(cfg_data);
        tsp_pkg::CFG_ALT_UPPER: alt_hi   <= $signed(cfg_data);
        tsp_pkg::CFG_ALT_RATE:  alt_rate <= cfg_data[A-2:0];
        tsp_pkg::CFG_AZ_RATE:   az_rate  <= cfg_data[A-2:0];
        tsp_pkg::CFG_ALT_PARK:  alt_park <= cfg_data;
        tsp_pkg::CFG_AZ_PARK:   az_park  <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick arithmetic
  logic              moving;
  logic signed [A:0] aerr;
  logic [A:0]        amag;
  logic              a_snap, a_zero;
  logic [A-1:0]      zd, zmag;
  logic              z_neg, z_snap, z_zero;
  logic [PW-1:0]     prod_a, prod_z, prod_a_sh, prod_z_sh;
  logic [A+1:0]      da;
  logic [A-1:0]      dz;
  logic signed [NW-1:0] a_base, a_step, np, np_lo, lo_ext, hi_ext;
  logic              adir_pos, adir_neg, zdir_pos, zdir_neg;
  logic [A-1:0]      az_base;
  logic signed [A-1:0] alt_moved;
  logic [A-1:0]      az_moved;
  logic              goto_bad;
  logic signed [A-1:0] goto_alt;

  assign moving = mode != tsp_pkg::MODE_IDLE && mode != tsp_pkg::MODE_PARKED;
  assign aerr   = {alt_goal[A-1], alt_goal} - {alt_pos[A-1], alt_pos};
  assign amag   = aerr[A] ? -aerr : aerr;
  assign a_snap = amag < {2'b00, alt_rate};
  assign a_zero = a_snap || aerr == '0;
  assign zd     = az_goal - az_pos;
  assign z_neg  = zd > HALF;
  assign zmag   = z_neg ? -zd : zd;
  assign z_snap = zmag < {1'b0, az_rate};
  assign z_zero = z_snap || zd == '0;

  assign prod_a    = PW'(alt_rate) * PW'(elapsed);
  assign prod_z    = PW'(az_rate) * PW'(elapsed);
  assign prod_a_sh = prod_a >> TIME_FRAC_BITS;
  assign prod_z_sh = prod_z >> TIME_FRAC_BITS;
  assign da        = (prod_a_sh > PW'(CAP)) ? CAP : prod_a_sh[A+1:0];
  assign dz        = prod_z_sh[A-1:0];

  assign adir_pos = !a_zero && !aerr[A];
  assign adir_neg = !a_zero && aerr[A];
  assign zdir_pos = !z_zero && !z_neg;
  assign zdir_neg = !z_zero && z_neg;

  assign a_base = NW'(a_snap ? alt_goal : alt_pos);
  assign a_step = adir_pos ? $signed({1'b0, da}) :
                  adir_neg ? -$signed({1'b0, da}) : '0;
  assign np     = a_base + a_step;
  assign lo_ext = NW'(alt_lo);
  assign hi_ext = NW'(alt_hi);
  // upper limit wins when the limits cross
  assign np_lo     = (np < lo_ext) ? lo_ext : np;
  assign alt_moved = (np_lo > hi_ext) ? alt_hi : np_lo[A-1:0];

  assign az_base  = z_snap ? az_goal : az_pos;
  assign az_moved = zdir_pos ? az_base + dz : zdir_neg ? az_base - dz : az_base;

  assign goto_bad = cmd_alt < alt_lo || cmd_alt > alt_hi;
  assign goto_alt = goto_bad ? alt_goal : cmd_alt;

  // next state
  always_comb begin
    mode_next      = mode;
    alt_pos_next   = alt_pos;
    az_pos_next    = az_pos;
    alt_goal_next  = alt_goal;
    az_goal_next   = az_goal;
    last_time_next = last_time;
    elapsed_next   = elapsed;
    unique case (op)
      tsp_pkg::OP_TICK: begin
        if (moving) begin
          if (a_zero && z_zero) begin
            alt_pos_next = a_snap ? alt_goal : alt_pos;
            az_pos_next  = az_base;
            mode_next    = (mode == tsp_pkg::MODE_PARKING) ? tsp_pkg::MODE_PARKED
                                                           : tsp_pkg::MODE_IDLE;
          end else begin
            alt_pos_next = alt_moved;
            az_pos_next  = az_moved;
          end
        end
      end
      tsp_pkg::OP_CLOCK: begin
        if (cmd_time > last_time) begin
          elapsed_next   = cmd_time - last_time;
          last_time_next = cmd_time;
        end
      end
      tsp_pkg::OP_GOTO: begin
        if (mode != tsp_pkg::MODE_PARKED) begin
          alt_goal_next = goto_alt;
          az_goal_next  = cmd_az;
          mode_next     = (alt_pos == goto_alt && az_pos == cmd_az) ? tsp_pkg::MODE_IDLE
                                                                   : tsp_pkg::MODE_SLEWING;
        end
      end
      tsp_pkg::OP_PARK: begin
        mode_next     = tsp_pkg::MODE_PARKING;
        alt_goal_next = $signed(alt_park);
        az_goal_next  = az_park;
      end
      tsp_pkg::OP_STOP: begin
        mode_next = tsp_pkg::MODE_IDLE;
      end
      tsp_pkg::OP_HOME: begin
        mode_next     = tsp_pkg::MODE_HOMING;
        alt_goal_next = '0;
        az_goal_next  = '0;
      end
      default: ;
    endcase
  end

  // result fields
  logic       res_range;
  logic [1:0] res_adir, res_zdir;

  always_comb begin
    res_range = 1'b0;
    res_adir  = tsp_pkg::DIR_ZERO;
    res_zdir  = tsp_pkg::DIR_ZERO;
    unique case (op)
      tsp_pkg::OP_TICK: begin
        if (moving && !(a_zero && z_zero)) begin
          res_adir = adir_pos ? tsp_pkg::DIR_POS : adir_neg ? tsp_pkg::DIR_NEG
                                                            : tsp_pkg::DIR_ZERO;
          res_zdir = zdir_pos ? tsp_pkg::DIR_POS : zdir_neg ? tsp_pkg::DIR_NEG
                                                            : tsp_pkg::DIR_ZERO;
        end
      end
      tsp_pkg::OP_GOTO: begin
        res_range = mode != tsp_pkg::MODE_PARKED && goto_bad;
      end
      default: ;
    endcase
  end

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= tsp_pkg::MODE_PARKED;
      alt_pos   <= '0;
      az_pos    <= '0;
      alt_goal  <= '0;
      az_goal   <= '0;
      last_time <= '0;
      elapsed   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        mode      <= mode_next;
        alt_pos   <= alt_pos_next;
        az_pos    <= az_pos_next;
        alt_goal  <= alt_goal_next;
        az_goal   <= az_goal_next;
        last_time <= last_time_next;
        elapsed   <= elapsed_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  logic [RES_W-1:0] res_word;

  assign res_word = {res_zdir, res_adir, res_range, az_pos_next, alt_pos_next, mode_next};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= OUT_TDATA_W'(res_word);
    end
  end

endmodule

`default_nettype wire

>>> sv/two_axis_slew_positioner_top.sv
// channel   dir  signals                         beat
// s         in   s_tvalid s_tready s_tdata s_tuser  one request
// m         out  m_tvalid m_tready m_tdata          one result per request
// cfg       in   cfg_we cfg_index cfg_data           one register write
//
// one request per cycle sustained while m_tready is high; a beat goes into the queue,
// then the slot is read and executed in the same cycle, into the output register
// reset is synchronous: parked at the zero position, reset register values
// with m_tready low the result holds, the two-slot queue fills up to two beats,
// then s_tready drops
`default_nettype none

module two_axis_slew_positioner_top #(
  parameter int ANGLE_BITS     = 24,
  parameter int TIME_FRAC_BITS = 10
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  // sidereal_time, goal_alt, goal_az
  input  wire  [((tsp_pkg::TIME_W+2*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
  // req_type
  input  wire  [tsp_pkg::REQ_W-1:0]    s_tuser,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // mount_state, alt_now, az_now, range_error, alt_direction, az_direction
  output logic [((2*ANGLE_BITS+8+7)/8)*8-1:0] m_tdata,
  input  wire                          cfg_we,
  input  wire  [2:0]                   cfg_index,
  input  wire  [ANGLE_BITS-1:0]        cfg_data
);

  localparam int IN_TDATA_W  = ((tsp_pkg::TIME_W + 2 * ANGLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * ANGLE_BITS + 8 + 7) / 8) * 8;
  localparam int CMD_W       = tsp_pkg::REQ_W + tsp_pkg::TIME_W + 2 * ANGLE_BITS;

  logic             q_full;
  logic             q_push;
  logic [CMD_W-1:0] q_in;
  logic             q_valid;
  logic             q_pop;
  logic [CMD_W-1:0] q_out;

  tsp_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .IN_TDATA_W (IN_TDATA_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  tsp_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  tsp_back #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TIME_FRAC_BITS (TIME_FRAC_BITS),
    .OUT_TDATA_W    (OUT_TDATA_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

>>> sv/tsp_checker.sv
`default_nettype none

module tsp_checker #(
  parameter int ANGLE_BITS = 24
) (
  input wire                                       clk,
  input wire                                       rst,
  input wire                                       m_tvalid,
  input wire                                       m_tready,
  input wire [((2*ANGLE_BITS+8+7)/8)*8-1:0]        m_tdata
);

  localparam int A = ANGLE_BITS;

  logic [2:0] st;
  logic       rng;
  logic [1:0] adir;
  logic [1:0] zdir;
  logic       still_state;

  assign st   = m_tdata[2:0];
  assign rng  = m_tdata[2*A+3];
  assign adir = m_tdata[2*A+5:2*A+4];
  assign zdir = m_tdata[2*A+7:2*A+6];
  assign still_state = st == tsp_pkg::MODE_IDLE || st == tsp_pkg::MODE_PARKED;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_range_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && rng |-> (st == tsp_pkg::MODE_IDLE || st == tsp_pkg::MODE_SLEWING)
      && adir == tsp_pkg::DIR_ZERO && zdir == tsp_pkg::DIR_ZERO)
    else $error("range flag outside a goto result");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> adir != 2'b10 && zdir != 2'b10)
    else $error("bad direction code");

  a_dir_moving: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (adir != tsp_pkg::DIR_ZERO || zdir != tsp_pkg::DIR_ZERO) |-> !still_state)
    else $error("motion reported while idle or parked");

endmodule

bind two_axis_slew_positioner_top tsp_checker #(
  .ANGLE_BITS (ANGLE_BITS)
) u_tsp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/two_axis_slew_positioner_top_tb.sv
`default_nettype none

module two_axis_slew_positioner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsp_pkg::*;

  localparam int ANGLE_BITS = 24;
  localparam int TIME_FRAC = 10;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 56;
  localparam int STUCK_LIMIT = 2000;

  localparam longint ANGLE_MASK = 64'hFFFFFF;
  localparam longint RATE_MASK = 64'h7FFFFF;
  localparam longint HALF_TURN = 64'h800000;
  localparam longint FULL_TURN = 64'h1000000;
  localparam longint ALT_STEP_CAP = 64'h2000000;
  localparam longint QUARTER_TURN = 64'h400000;
  localparam longint DEFAULT_SLEW = 46603;

  // codes past the last request, which the block must ignore
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  typedef struct packed {
    logic [2:0]  state;
    logic [23:0] alt;
    logic [23:0] az;
    logic        rerr;
    logic [1:0]  adir;
    logic [1:0]  zdir;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;  // sidereal_time, goal_alt, goal_az
  logic [2:0] s_tuser = '0;           // req_type
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;       // mount_state, alt_now, az_now, range_error,
                                      // alt_direction, az_direction
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [ANGLE_BITS-1:0] cfg_data = '0;

  // mount state as the block should hold it
  mode_t mount_mode = MODE_PARKED;
  longint alt_pos = 0;
  longint az_pos = 0;
  longint alt_tgt = 0;
  longint az_tgt = 0;
  logic [31:0] t_last = '0;
  longint elapsed_ticks = 0;
  longint lim_lo = 0;
  longint lim_hi = QUARTER_TURN;
  longint rate_alt = DEFAULT_SLEW;
  longint rate_az = DEFAULT_SLEW;
  longint park_alt = 0;
  longint park_az = 0;

  status_t predicted_status[$];
  int errors = 0;
  int requests_sent = 0;
  int send_gap_max = 14;
  int recv_stall_max = 14;
  int ready_hold = 0;
  int ready_draw;
  int stuck_cycles = 0;

  two_axis_slew_positioner_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint sext24(input logic [23:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [1:0] dir_code(input int d);
    if (d > 0) return DIR_POS;
    if (d < 0) return DIR_NEG;
    return DIR_ZERO;
  endfunction

  function automatic status_t advance_mount(input logic [2:0] req, input logic [31:0] stamp,
                                            input logic [23:0] ga_bits,
                                            input logic [23:0] gz_bits);
    longint aerr, zerr, amag, zmag, da, dz, np, ga, zd;
    int adir, zdir;
    logic rerr;
    status_t r;
    adir = 0;
    zdir = 0;
    rerr = 1'b0;
    case (req)
      REQ_TICK: begin
        if (mount_mode != MODE_IDLE && mount_mode != MODE_PARKED) begin
          aerr = alt_tgt - alt_pos;
          zd = (az_tgt - az_pos) & ANGLE_MASK;
          zerr = (zd > HALF_TURN) ? zd - FULL_TURN : zd;
          amag = (aerr < 0) ? -aerr : aerr;
          zmag = (zerr < 0) ? -zerr : zerr;
          if (amag < rate_alt) begin
            aerr = 0;
            alt_pos = alt_tgt;
          end
          if (zmag < rate_az) begin
            zerr = 0;
            az_pos = az_tgt;
          end
          if (aerr == 0 && zerr == 0) begin
            if (mount_mode == MODE_PARKING) mount_mode = MODE_PARKED;
            else mount_mode = MODE_IDLE;
          end else begin
            da = (rate_alt * elapsed_ticks) >> TIME_FRAC;
            dz = (rate_az * elapsed_ticks) >> TIME_FRAC;
            if (da > ALT_STEP_CAP) da = ALT_STEP_CAP;
            adir = (aerr > 0) ? 1 : ((aerr < 0) ? -1 : 0);
            zdir = (zerr > 0) ? 1 : ((zerr < 0) ? -1 : 0);
            np = alt_pos + adir * da;
            // crossed limits: the upper one wins
            if (np < lim_lo) np = lim_lo;
            if (np > lim_hi) np = lim_hi;
            alt_pos = np;
            if (zdir > 0) az_pos = (az_pos + dz) & ANGLE_MASK;
            else if (zdir < 0) az_pos = (az_pos - dz) & ANGLE_MASK;
          end
        end
      end
      REQ_CLOCK: begin
        if (stamp > t_last) begin
          elapsed_ticks = stamp - t_last;
          t_last = stamp;
        end
      end
      REQ_GOTO: begin
        if (mount_mode != MODE_PARKED) begin
          ga = sext24(ga_bits);
          if (ga < lim_lo || ga > lim_hi) rerr = 1'b1;
          else alt_tgt = ga;
          az_tgt = gz_bits;
          if (alt_pos == alt_tgt && az_pos == az_tgt) mount_mode = MODE_IDLE;
          else mount_mode = MODE_SLEWING;
        end
      end
      REQ_PARK: begin
        mount_mode = MODE_PARKING;
        alt_tgt = park_alt;
        az_tgt = park_az;
      end
      REQ_STOP: mount_mode = MODE_IDLE;
      REQ_HOME: begin
        mount_mode = MODE_HOMING;
        alt_tgt = 0;
        az_tgt = 0;
      end
      default: ;
    endcase
    r.state = mount_mode;
    r.alt = alt_pos[23:0];
    r.az = az_pos[23:0];
    r.rerr = rerr;
    r.adir = dir_code(adir);
    r.zdir = dir_code(zdir);
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // result side: random back-pressure and comparison
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) m_tready <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      ready_draw = $urandom_range(0, recv_stall_max);
      if (ready_draw != 0) begin
        m_tready <= 1'b0;
        ready_hold <= ready_draw;
      end
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_status.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, got %h",
                 $time, m_tdata);
      end else begin
        want = predicted_status.pop_front();
        check_field("mount_state", want.state, m_tdata[2:0]);
        check_field("alt_now", want.alt, m_tdata[26:3]);
        check_field("az_now", want.az, m_tdata[50:27]);
        check_field("range_error", want.rerr, m_tdata[51]);
        check_field("alt_direction", want.adir, m_tdata[53:52]);
        check_field("az_direction", want.zdir, m_tdata[55:54]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
      $display("two_axis_slew_positioner_top_tb: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_req(input logic [2:0] req, input logic [31:0] stamp,
                          input logic [23:0] ga, input logic [23:0] gz);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {gz, ga, stamp};
    do @(posedge clk); while (!s_tready);
    predicted_status.push_back(advance_mount(req, stamp, ga, gz));
    requests_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_index_t idx, input longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    @(posedge clk);
  endtask

  task automatic load_settings(input longint lo, input longint hi, input longint ra,
                               input longint rz, input longint pa, input longint pz);
    wait_idle();
    cfg_put(CFG_ALT_LOWER, lo);
    cfg_put(CFG_ALT_UPPER, hi);
    cfg_put(CFG_ALT_RATE, ra);
    cfg_put(CFG_AZ_RATE, rz);
    cfg_put(CFG_ALT_PARK, pa);
    cfg_put(CFG_AZ_PARK, pz);
    cfg_we <= 1'b0;
    lim_lo = sext24(lo[23:0]);
    lim_hi = sext24(hi[23:0]);
    rate_alt = ra & RATE_MASK;
    rate_az = rz & RATE_MASK;
    park_alt = sext24(pa[23:0]);
    park_az = pz & ANGLE_MASK;
    @(posedge clk);
  endtask

  function automatic logic [31:0] next_stamp();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return (t_last < 4) ? t_last : t_last - $urandom_range(0, 3);
    if (pick < 85) return t_last + $urandom_range(1, 1024);
    if (pick < 97) return t_last + $urandom_range(1025, 65536);
    return t_last + $urandom_range(65537, 1 << 20);
  endfunction

  function automatic longint step_span(input longint rate);
    return (rate > (1 << 20)) ? (1 << 20) : rate + 1;
  endfunction

  function automatic logic [23:0] pick_alt_goal();
    int pick;
    longint v, span;
    pick = $urandom_range(0, 9);
    span = step_span(rate_alt);
    if (pick < 4) begin
      v = alt_pos + $urandom_range(0, 8 * span) - 4 * span;
    end else if (pick < 7 && lim_lo <= lim_hi) begin
      v = lim_lo + $urandom_range(0, lim_hi - lim_lo);
    end else if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: v = lim_lo;
        1: v = lim_hi;
        2: v = lim_lo - 1;
        default: v = lim_hi + 1;
      endcase
    end else begin
      v = $urandom;
    end
    return v[23:0];
  endfunction

  function automatic logic [23:0] pick_az_goal();
    longint v, span;
    span = step_span(rate_az);
    if ($urandom_range(0, 1) == 0) v = az_pos + $urandom_range(0, 8 * span) - 4 * span;
    else v = $urandom;
    return v[23:0];
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_req(REQ_CLOCK, next_stamp(), $urandom, $urandom);
      send_req(REQ_TICK, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic run_episode();
    int kind;
    logic [2:0] req;
    kind = $urandom_range(0, 99);
    send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    if (kind < 55) begin
      if (mount_mode == MODE_PARKED || $urandom_range(0, 3) == 0)
        send_req(REQ_STOP, $urandom, $urandom, $urandom);
      send_req(REQ_CLOCK, next_stamp(), $urandom, $urandom);
      send_req(REQ_GOTO, $urandom, pick_alt_goal(), pick_az_goal());
      send_ticks($urandom_range(1, 24));
    end else if (kind < 70) begin
      send_req(REQ_PARK, $urandom, $urandom, $urandom);
      send_ticks($urandom_range(1, 16));
    end else if (kind < 82) begin
      send_req(REQ_HOME, $urandom, $urandom, $urandom);
      send_ticks($urandom_range(1, 16));
    end else if (kind < 90) begin
      send_req(REQ_STOP, $urandom, $urandom, $urandom);
      send_ticks($urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        req = $urandom_range(0, 7);
        if (req == REQ_CLOCK) send_req(req, next_stamp(), $urandom, $urandom);
        else send_req(req, $urandom, $urandom, $urandom);
      end
    end
    if ($urandom_range(0, 39) == 0) wait_idle();
  endtask

  task automatic test_random_traffic(input int n);
    int start;
    start = requests_sent;
    while (requests_sent - start < n) run_episode();
  endtask

  task automatic test_parked_and_clock();
    send_req(REQ_TICK, $urandom, $urandom, $urandom);
    send_req(REQ_GOTO, 32'd0, 24'd1000, 24'd1000);
    send_req(REQ_CLOCK, 32'd1024, 24'd0, 24'd0);
    send_req(REQ_CLOCK, 32'd1000, 24'd0, 24'd0);
    send_req(REQ_CLOCK, 32'd1024, 24'd0, 24'd0);
    send_req(REQ_STOP, 32'd0, 24'd0, 24'd0);
    send_req(REQ_TICK, 32'd0, 24'd0, 24'd0);
  endtask

  task automatic test_goto_cases();
    send_req(REQ_GOTO, 32'd0, 24'd0, 24'd0);
    // below the lower limit, azimuth exactly half a turn away
    send_req(REQ_GOTO, 32'd0, 24'hFFFFFF, 24'h800000);
    send_req(REQ_TICK, 32'd0, 24'd0, 24'd0);
    send_req(REQ_GOTO, 32'hFFFFFFFF, 24'h7FFFFF, 24'hFFFFFF);
    send_req(REQ_GOTO, 32'd0, 24'h800000, 24'h000000);
    send_req(REQ_GOTO, 32'd0, 24'h400000, 24'd100);
    send_req(REQ_TICK, 32'd0, 24'd0, 24'd0);
    send_req(REQ_TICK, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
  endtask

  task automatic test_park_home_stop();
    longint a, z;
    send_req(REQ_PARK, 32'd0, 24'd0, 24'd0);
    send_req(REQ_TICK, 32'd0, 24'd0, 24'd0);
    send_req(REQ_HOME, 32'd0, 24'd0, 24'd0);
    send_req(REQ_TICK, 32'd0, 24'd0, 24'd0);
    send_req(REQ_SPARE_A, $urandom, $urandom, $urandom);
    send_req(REQ_SPARE_B, $urandom, $urandom, $urandom);
    send_req(REQ_STOP, 32'd0, 24'd0, 24'd0);
    // small step, snaps on the next tick
    a = alt_pos + 10;
    z = az_pos - 6;
    send_req(REQ_GOTO, 32'd0, a[23:0], z[23:0]);
    send_req(REQ_TICK, 32'd0, 24'd0, 24'd0);
    send_req(REQ_TICK, 32'd0, 24'd0, 24'd0);
  endtask

  task automatic test_random_settings(input int n);
    longint lo, hi, t, ra, rz;
    lo = -64'sd4194304 + $urandom_range(0, 8388608);
    hi = -64'sd4194304 + $urandom_range(0, 8388608);
    if (lo > hi && $urandom_range(0, 3) != 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    ra = ($urandom_range(0, 1) == 0) ? $urandom_range(2000, 200000)
                                     : $urandom_range(0, 4194304);
    rz = ($urandom_range(0, 1) == 0) ? $urandom_range(2000, 200000)
                                     : $urandom_range(0, 4194304);
    load_settings(lo, hi, ra, rz, -64'sd4194304 + $urandom_range(0, 8388608),
                  $urandom_range(0, 16777215));
    test_random_traffic(n);
  endtask

  task automatic test_time_extremes();
    repeat (3) send_req(REQ_CLOCK, $urandom, $urandom, $urandom);
    send_req(REQ_CLOCK, 32'hFFFFFFFF, 24'd0, 24'd0);
    send_req(REQ_CLOCK, 32'd0, 24'd0, 24'd0);
    send_req(REQ_STOP, 32'd0, 24'd0, 24'd0);
    send_req(REQ_GOTO, 32'd0, pick_alt_goal(), pick_az_goal());
    send_ticks(3);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_parked_and_clock();
    test_goto_cases();
    test_park_home_stop();
    test_random_traffic(215);
    load_settings(-64'sd4194304, 64'sd4194304, 64'sd4194304, 64'sd4194304,
                  -64'sd4194304, 64'sd16777215);
    test_random_traffic(215);
    // crossed limits, zero rates: no steps, but altitude is clamped to the upper limit
    load_settings(64'sd4194304, -64'sd4194304, 64'sd0, 64'sd0, 64'sd4194304, 64'sd0);
    test_random_traffic(215);
    test_random_settings(215);
    test_random_settings(215);
    test_random_settings(215);
    load_settings(-64'sd4194304, 64'sd4194304, DEFAULT_SLEW, DEFAULT_SLEW,
                  -64'sd4194304 + $urandom_range(0, 8388608), $urandom_range(0, 16777215));
    test_random_traffic(215);
    test_time_extremes();
    wait_idle();
    if (errors == 0) $display("two_axis_slew_positioner_top_tb: PASS");
    else $display("two_axis_slew_positioner_top_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
